### hdl/frb_pkg.sv
// Shared types and constants of the ring-buffer FIR filter.
`timescale 1ns / 1ps

package frb_pkg;

  localparam int ACC_W   = 40;
  localparam int OUT_W   = 16;
  localparam int SHIFT_W = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_COEF   = 1'b1
  } item_mode_e;

  typedef enum logic {
    REG_TAP_COUNT = 1'b0,
    REG_OUT_SHIFT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic ring_we;
    logic coef_we;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tap_ctl_t;

endpackage

### hdl/frb_in_if.sv
// Input channel: sample items and coefficient writes.
`timescale 1ns / 1ps

interface frb_in_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16,
  parameter int IDX_W        = 8
);
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic        [IDX_W-1:0]        coef_index;
  logic signed [COEF_WIDTH-1:0]   coef_value;

  modport source (output valid, output mode, output sample, output coef_index,
                  output coef_value, input ready);
  modport sink   (input valid, input mode, input sample, input coef_index,
                  input coef_value, output ready);
endinterface

### hdl/frb_out_if.sv
// Output channel: filtered samples with saturation flag.
`timescale 1ns / 1ps

interface frb_out_if;
  import frb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;
  logic                    saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

### hdl/frb_regs.sv
// APB configuration registers: tap count and output shift.
`timescale 1ns / 1ps

module frb_regs #(
  parameter int  MAX_TAPS = 256,
  localparam int TW       = $clog2(MAX_TAPS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frb_pkg::PADDR_W-1:0]   paddr,
  input  logic [frb_pkg::PDATA_W-1:0]   pwdata,
  output logic [frb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [TW-1:0]                 tap_count_o,
  output logic [frb_pkg::SHIFT_W-1:0]   out_shift_o
);
  import frb_pkg::*;

  logic [TW-1:0]      tap_count_q;
  logic [SHIFT_W-1:0] out_shift_q;
  logic               wr_en;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TW'(MAX_TAPS);
      out_shift_q <= SHIFT_W'(15);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TAP_COUNT: tap_count_q <= pwdata[TW-1:0];
        REG_OUT_SHIFT: out_shift_q <= pwdata[SHIFT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TAP_COUNT: prdata = PDATA_W'(tap_count_q);
      REG_OUT_SHIFT: prdata = PDATA_W'(out_shift_q);
    endcase
  end

  assign tap_count_o = tap_count_q;
  assign out_shift_o = out_shift_q;
endmodule

### hdl/frb_store.sv
// Sample ring and coefficient memories, one write and one registered read port each.
`timescale 1ns / 1ps

module frb_store #(
  parameter int  MAX_TAPS     = 256,
  parameter int  SAMPLE_WIDTH = 16,
  parameter int  COEF_WIDTH   = 16,
  localparam int AW           = $clog2(MAX_TAPS)
) (
  input  logic                    clk_i,
  input  frb_pkg::mem_ctl_t       mem_i,
  input  logic [AW-1:0]           ring_waddr_i,
  input  logic [SAMPLE_WIDTH-1:0] ring_wdata_i,
  input  logic [AW-1:0]           coef_waddr_i,
  input  logic [COEF_WIDTH-1:0]   coef_wdata_i,
  input  logic [AW-1:0]           ring_raddr_i,
  input  logic [AW-1:0]           coef_raddr_i,
  output logic [SAMPLE_WIDTH-1:0] ring_rdata_o,
  output logic [COEF_WIDTH-1:0]   coef_rdata_o
);
  import frb_pkg::*;

  logic [SAMPLE_WIDTH-1:0] ring_mem [MAX_TAPS];
  logic [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];

  always_ff @(posedge clk_i) begin
    if (mem_i.ring_we) begin
      ring_mem[ring_waddr_i] <= ring_wdata_i;
    end
    if (mem_i.rd_en) begin
      ring_rdata_o <= ring_mem[ring_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_i.coef_we) begin
      coef_mem[coef_waddr_i] <= coef_wdata_i;
    end
    if (mem_i.rd_en) begin
      coef_rdata_o <= coef_mem[coef_raddr_i];
    end
  end
endmodule

### hdl/frb_seq.sv
// Sequencer: clearing pass, item intake, tap address walk and drain wait.
`timescale 1ns / 1ps

module frb_seq #(
  parameter int  MAX_TAPS     = 256,
  parameter int  SAMPLE_WIDTH = 16,
  parameter int  COEF_WIDTH   = 16,
  localparam int AW           = $clog2(MAX_TAPS),
  localparam int TW           = $clog2(MAX_TAPS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  frb_in_if.sink                  in_i,
  input  logic [TW-1:0]           tap_count_i,
  input  logic                    dp_busy_i,
  output frb_pkg::mem_ctl_t       mem_o,
  output frb_pkg::tap_ctl_t       tap_o,
  output logic [AW-1:0]           ring_waddr_o,
  output logic [SAMPLE_WIDTH-1:0] ring_wdata_o,
  output logic [AW-1:0]           coef_waddr_o,
  output logic [COEF_WIDTH-1:0]   coef_wdata_o,
  output logic [AW-1:0]           ring_raddr_o,
  output logic [AW-1:0]           coef_raddr_o
);
  import frb_pkg::*;

  seq_state_e    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] j_q, j_d;

  logic [TW-1:0] taps_eff;
  logic [TW-1:0] taps_m1;
  logic [TW-1:0] pos_inc;
  logic [AW-1:0] pos;
  logic [AW-1:0] wp_next;
  logic          tap_last;

  // Zero taps act as one, anything above the store depth is clipped.
  always_comb begin
    priority if (tap_count_i == '0) begin
      taps_eff = TW'(1);
    end else if (tap_count_i > TW'(MAX_TAPS)) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = tap_count_i;
    end
  end

  assign taps_m1  = taps_eff - TW'(1);
  // Restart the ring when the tap count was lowered to or below the position.
  assign pos      = (TW'(wp_q) >= taps_eff) ? '0 : wp_q;
  assign pos_inc  = TW'(pos) + TW'(1);
  assign wp_next  = (pos_inc == taps_eff) ? '0 : pos_inc[AW-1:0];
  assign tap_last = (TW'(k_q) == taps_m1);

  assign in_i.ready   = (state_q == ST_IDLE);
  assign ring_raddr_o = j_q;
  assign coef_raddr_o = k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      k_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      k_q     <= k_d;
      j_q     <= j_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    wp_d         = wp_q;
    k_d          = k_q;
    j_d          = j_q;
    mem_o        = '0;
    tap_o        = '0;
    ring_waddr_o = clr_q;
    ring_wdata_o = '0;
    coef_waddr_o = clr_q;
    coef_wdata_o = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_o.ring_we = 1'b1;
        mem_o.coef_we = 1'b1;
        clr_d         = clr_q + AW'(1);
        if (clr_q == AW'(MAX_TAPS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.mode == MODE_COEF) begin
            // Drop writes beyond the store depth.
            mem_o.coef_we = (TW'(in_i.coef_index) < TW'(MAX_TAPS));
            coef_waddr_o  = in_i.coef_index;
            coef_wdata_o  = in_i.coef_value;
          end else begin
            mem_o.ring_we = 1'b1;
            ring_waddr_o  = pos;
            ring_wdata_o  = in_i.sample;
            j_d           = pos;
            k_d           = '0;
            wp_d          = wp_next;
            state_d       = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        mem_o.rd_en = 1'b1;
        tap_o.vld   = 1'b1;
        tap_o.first = (k_q == '0);
        tap_o.last  = tap_last;
        k_d         = k_q + AW'(1);
        j_d         = (j_q == '0) ? taps_m1[AW-1:0] : j_q - AW'(1);
        if (tap_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!dp_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

### hdl/frb_mac.sv
// Multiply-accumulate pipeline, rounding, shift, saturation and output register.
`timescale 1ns / 1ps

module frb_mac #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  frb_pkg::tap_ctl_t           tap_i,
  input  logic [SAMPLE_WIDTH-1:0]     ring_rdata_i,
  input  logic [COEF_WIDTH-1:0]       coef_rdata_i,
  input  logic [frb_pkg::SHIFT_W-1:0] out_shift_i,
  output logic                        busy_o,
  frb_out_if.source                   out_o
);
  import frb_pkg::*;

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int RW = ACC_W + 1;

  tap_ctl_t               c1_q, c2_q;
  logic                   done_q;
  logic                   rnd_vld_q;
  logic                   out_vld_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [ACC_W-1:0] prod_ext;
  logic [ACC_W-1:0]       acc_q;
  logic signed [RW-1:0]   rnd_add;
  logic signed [RW-1:0]   rnd_q;
  logic signed [RW-1:0]   shifted;
  logic [RW-OUT_W:0]      upper;
  logic                   sat_hi, sat_lo;
  logic signed [OUT_W-1:0] filt_d, filt_q;
  logic                   sat_q;
  logic                   load;

  assign prod_ext = ACC_W'(prod_q);
  assign rnd_add  = (out_shift_i != '0) ? (RW'(1) << (out_shift_i - SHIFT_W'(1))) : '0;

  // Control pipeline tracks the read data one stage behind the memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q      <= '0;
      c2_q      <= '0;
      done_q    <= 1'b0;
      rnd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      c1_q   <= tap_i;
      c2_q   <= c1_q;
      done_q <= c2_q.vld && c2_q.last;
      if (done_q) begin
        rnd_vld_q <= 1'b1;
      end else if (load) begin
        rnd_vld_q <= 1'b0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c1_q.vld) begin
      prod_q <= $signed(coef_rdata_i) * $signed(ring_rdata_i);
    end
    if (c2_q.vld) begin
      acc_q <= c2_q.first ? prod_ext : acc_q + prod_ext;
    end
    if (done_q) begin
      rnd_q <= $signed({acc_q[ACC_W-1], acc_q}) + rnd_add;
    end
    if (load) begin
      filt_q <= filt_d;
      sat_q  <= sat_hi || sat_lo;
    end
  end

  // Clip when the bits above the output sign disagree with it.
  assign shifted = rnd_q >>> out_shift_i;
  assign upper   = shifted[RW-1:OUT_W-1];
  assign sat_hi  = !shifted[RW-1] && (|upper);
  assign sat_lo  = shifted[RW-1] && !(&upper);

  always_comb begin
    priority if (sat_hi) begin
      filt_d = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (sat_lo) begin
      filt_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      filt_d = shifted[OUT_W-1:0];
    end
  end

  assign load            = rnd_vld_q && (!out_vld_q || out_o.ready);
  assign busy_o          = c1_q.vld || c2_q.vld || done_q || rnd_vld_q;
  assign out_o.valid     = out_vld_q;
  assign out_o.filtered  = filt_q;
  assign out_o.saturated = sat_q;
endmodule

### hdl/fir_filter_ring_buffer_top.sv
// Top level of the direct-form FIR filter over a circular sample store.
//
//  channel  dir  handshake        payload
//  in_i     in   valid / ready    mode, sample, coef_index, coef_value
//  out_o    out  valid / ready    filtered, saturated
//  apb      in   psel, penable    paddr, pwdata, prdata (tap_count @0, out_shift @4)
//
// A coefficient write leaves in_i.ready high. A sample transfer lowers it while
// T taps are walked, T being tap_count clipped to 1..MAX_TAPS: one shared
// multiplier reads one coefficient and one ring sample per cycle from the two
// memories, then a five-stage drain runs before in_i.ready rises again.
// After reset both memories are zeroed with in_i.ready low.
// A finished result waits in the output register; the next item is taken
// meanwhile and stalls only at its own result if out_o is still full.
`timescale 1ns / 1ps

module fir_filter_ring_buffer_top #(
  parameter int  MAX_TAPS     = 256,
  parameter int  SAMPLE_WIDTH = 16,
  parameter int  COEF_WIDTH   = 16,
  localparam int AW           = $clog2(MAX_TAPS),
  localparam int TW           = $clog2(MAX_TAPS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  frb_in_if.sink                      in_i,
  frb_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frb_pkg::PADDR_W-1:0] paddr,
  input  logic [frb_pkg::PDATA_W-1:0] pwdata,
  output logic [frb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import frb_pkg::*;

  logic [TW-1:0]           tap_count;
  logic [SHIFT_W-1:0]      out_shift;
  logic                    dp_busy;
  mem_ctl_t                mem_ctl;
  tap_ctl_t                tap_ctl;
  logic [AW-1:0]           ring_waddr, coef_waddr, ring_raddr, coef_raddr;
  logic [SAMPLE_WIDTH-1:0] ring_wdata, ring_rdata;
  logic [COEF_WIDTH-1:0]   coef_wdata, coef_rdata;

  frb_regs #(.MAX_TAPS(MAX_TAPS)) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tap_count_o (tap_count),
    .out_shift_o (out_shift)
  );

  frb_seq #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .tap_count_i  (tap_count),
    .dp_busy_i    (dp_busy),
    .mem_o        (mem_ctl),
    .tap_o        (tap_ctl),
    .ring_waddr_o (ring_waddr),
    .ring_wdata_o (ring_wdata),
    .coef_waddr_o (coef_waddr),
    .coef_wdata_o (coef_wdata),
    .ring_raddr_o (ring_raddr),
    .coef_raddr_o (coef_raddr)
  );

  frb_store #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_store (
    .clk_i        (clk_i),
    .mem_i        (mem_ctl),
    .ring_waddr_i (ring_waddr),
    .ring_wdata_i (ring_wdata),
    .coef_waddr_i (coef_waddr),
    .coef_wdata_i (coef_wdata),
    .ring_raddr_i (ring_raddr),
    .coef_raddr_i (coef_raddr),
    .ring_rdata_o (ring_rdata),
    .coef_rdata_o (coef_rdata)
  );

  frb_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tap_i        (tap_ctl),
    .ring_rdata_i (ring_rdata),
    .coef_rdata_i (coef_rdata),
    .out_shift_i  (out_shift),
    .busy_o       (dp_busy),
    .out_o        (out_o)
  );

`ifndef SYNTHESIS
  // No new item while a previous sample is still in the pipeline.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !dp_busy)
    else $error("item transfer while datapath busy");

  // A sample transfer starts the tap walk, so intake closes next cycle.
  a_sample_closes_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.mode == MODE_SAMPLE) |=> !in_i.ready)
    else $error("intake open after sample transfer");

  // Tap reads never coincide with a memory write.
  a_read_write_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.rd_en |-> !(mem_ctl.ring_we || mem_ctl.coef_we))
    else $error("memory read and write in the same cycle");
`endif
endmodule
